[rtl/lir_pkg.sv]
`default_nettype none

package lir_pkg;

    // Sample and fixed-point formats.
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = FRAC_BITS + 5;
    localparam int STEP_W    = 20;
    localparam int CFG_W     = STEP_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_MIN = STEP_ONE >> 6;

    // Interpolation datapath widths.
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = FRAC_BITS + 1 + DIFF_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int RND_W  = NUM_W - FRAC_BITS;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 1'b1;

    // Command kinds passed from the front end to the back end.
    localparam logic CMD_PASS   = 1'b0;
    localparam logic CMD_INTERP = 1'b1;

    // Command queue geometry.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/lir_front.sv]
`default_nettype none

module lir_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          bypass,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] s_in_sample,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output lir_pkg::cmd_t                      cmd
);
    import lir_pkg::*;

    logic                       have_prev_reg, have_prev_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                       accept;

    assign s_ready = cmd_ready;
    assign accept  = s_valid && s_ready;

    // In interpolation mode, the first sample after reset only primes the previous-sample register.
    assign cmd_valid = s_valid && (bypass || have_prev_reg);
    assign cmd.kind  = bypass ? CMD_PASS : CMD_INTERP;
    assign cmd.a     = bypass ? s_in_sample : prev_reg;
    assign cmd.b     = s_in_sample;

    always_comb begin
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        if (accept && !bypass) begin
            have_prev_next = 1'b1;
            prev_next      = s_in_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
        end else begin
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lir_cmd_fifo.sv]
`default_nettype none

module lir_cmd_fifo (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire lir_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  wire logic     pop_en,
    output lir_pkg::cmd_t pop_cmd
);
    import lir_pkg::*;

    cmd_t               entries_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CMDQ_CW'(CMDQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/lir_back.sv]
`default_nettype none

module lir_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [lir_pkg::STEP_W-1:0]        step_q16,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_pop,
    input  wire lir_pkg::cmd_t                     cmd,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0]    m_out_sample,
    output logic                                   m_last_of_run
);
    import lir_pkg::*;

    typedef struct packed {
        logic                       pass;
        logic                       last;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [PROD_W-1:0]   prod;
    } stage_t;

    // Sequencer state.
    logic                       active_reg, active_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic signed [SAMPLE_W-1:0] a_reg, a_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;

    // Multiply stage and output register.
    logic                       s1_valid_reg, s1_valid_next;
    stage_t                     s1_reg, s1_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;

    logic                       out_adv, can_issue;
    logic [STEP_W-1:0]          step_eff;
    logic [POS_W-1:0]           pos_sum;
    logic                       sum_done;
    logic signed [SAMPLE_W-1:0] op_a;
    logic signed [DIFF_W-1:0]   op_diff;
    logic signed [DIFF_W-1:0]   head_diff;
    logic signed [PROD_W-1:0]   op_prod;

    logic signed [NUM_W-1:0]    num;
    logic [NUM_W-1:0]           mag;
    logic [NUM_W-1:0]           mag_rnd;
    logic [RND_W-1:0]           rmag;
    logic signed [SAMPLE_W-1:0] interp_val;

    assign out_adv   = !m_valid_reg || m_ready;
    assign can_issue = !s1_valid_reg || out_adv;
    assign step_eff  = (step_q16 < STEP_MIN) ? STEP_MIN : step_q16;
    assign pos_sum   = pos_reg + POS_W'(step_eff);
    assign sum_done  = (pos_sum >= POS_ONE);

    assign head_diff = DIFF_W'(cmd.b) - DIFF_W'(cmd.a);
    assign op_a      = active_reg ? a_reg : cmd.a;
    assign op_diff   = active_reg ? diff_reg : head_diff;
    assign op_prod   = $signed({1'b0, pos_reg[FRAC_BITS-1:0]}) * op_diff;

    always_comb begin
        active_next   = active_reg;
        pos_next      = pos_reg;
        a_next        = a_reg;
        diff_next     = diff_reg;
        cmd_pop       = 1'b0;
        s1_valid_next = s1_valid_reg && !out_adv;
        s1_next       = s1_reg;

        if (active_reg) begin
            if (can_issue) begin
                s1_valid_next = 1'b1;
                s1_next       = '{pass: 1'b0, last: sum_done, a: op_a, prod: op_prod};
                active_next   = !sum_done;
                pos_next      = sum_done ? pos_sum - POS_ONE : pos_sum;
            end
        end else if (cmd_valid && can_issue) begin
            cmd_pop = 1'b1;
            if (cmd.kind == CMD_PASS) begin
                s1_valid_next = 1'b1;
                s1_next       = '{pass: 1'b1, last: 1'b1, a: cmd.a, prod: '0};
            end else if (pos_reg >= POS_ONE) begin
                // Step above one: this sample yields nothing.
                pos_next = pos_reg - POS_ONE;
            end else begin
                s1_valid_next = 1'b1;
                s1_next       = '{pass: 1'b0, last: sum_done, a: op_a, prod: op_prod};
                active_next   = !sum_done;
                pos_next      = sum_done ? pos_sum - POS_ONE : pos_sum;
                a_next        = cmd.a;
                diff_next     = head_diff;
            end
        end
    end

    // Rounding half away from zero on the Q.FRAC_BITS value, then clamping.
    always_comb begin
        num     = ({{(NUM_W-SAMPLE_W){s1_reg.a[SAMPLE_W-1]}}, s1_reg.a} <<< FRAC_BITS)
                + {{(NUM_W-PROD_W){s1_reg.prod[PROD_W-1]}}, s1_reg.prod};
        mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        mag_rnd = mag + (NUM_W'(1) << (FRAC_BITS - 1));
        rmag    = mag_rnd[NUM_W-1:FRAC_BITS];
        if (!num[NUM_W-1]) begin
            interp_val = (rmag > RND_W'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_W'(rmag);
        end else begin
            interp_val = (rmag > (RND_W'(1) << (SAMPLE_W - 1))) ? SAMPLE_MIN
                                                                 : SAMPLE_W'(-rmag);
        end
    end

    assign m_valid_next = (s1_valid_reg && out_adv) || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            active_reg   <= active_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        diff_reg <= diff_next;
        s1_reg   <= s1_next;
        if (s1_valid_reg && out_adv) begin
            out_sample_reg <= s1_reg.pass ? s1_reg.a : interp_val;
            out_last_reg   <= s1_reg.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_sample  = out_sample_reg;
    assign m_last_of_run = out_last_reg;

endmodule

`default_nettype wire

[rtl/linear_interp_resampler_core.sv]
`default_nettype none

// Linear-interpolation resampler to 48 kHz. Each accepted request carries one signed
// 16-bit source sample. In interpolation mode the block produces every output that
// falls between the previous source sample and this one, each equal to
// prev + pos * (new - prev) rounded half away from zero, where pos is a Q5.16 read
// position that advances by step_q16 per output (steps below 1/64 count as 1/64, so
// at most 64 outputs arise per sample); m_last_of_run marks the final output of each
// sample. The first sample taken in interpolation mode after reset only primes the
// interpolator and yields no output, and a sample that arrives while the position is
// still at or above one yields none either. With bypass set, each sample comes out
// unchanged as a single output. Throughput is one output per clock while m_ready is
// high: a sample holds the sequencer until its last output has been issued, and the
// rate is set by the single-multiplier interpolation loop in the back end. A two-entry
// command queue between the front end and the back end lets input requests keep
// arriving while outputs are stalled. With the queue and the back end idle, the first
// output of a sample passes through the queue entry, the multiply stage and the output
// register before it is presented. Configuration must only be written while idle.

module linear_interp_resampler_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lir_pkg::CFG_W-1:0]           cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [lir_pkg::SAMPLE_W-1:0] s_in_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0]      m_out_sample,
    output logic                                     m_last_of_run
);
    import lir_pkg::*;

    // Configuration registers.
    logic [STEP_W-1:0] step_reg, step_next;
    logic              bypass_reg, bypass_next;

    // Front end to queue, and queue to back end.
    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_en;
    cmd_t pop_cmd;

    always_comb begin
        step_next   = step_reg;
        bypass_next = bypass_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STEP:   step_next   = cfg_wdata[STEP_W-1:0];
                REG_BYPASS: bypass_next = cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= STEP_ONE;
            bypass_reg <= 1'b1;
        end else begin
            step_reg   <= step_next;
            bypass_reg <= bypass_next;
        end
    end

    // The front end classifies each sample into a pass-through or interpolation command.
    lir_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bypass      (bypass_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_sample (s_in_sample),
        .cmd_valid   (push_valid),
        .cmd_ready   (push_ready),
        .cmd         (push_cmd)
    );

    lir_cmd_fifo u_cmdq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_cmd    (pop_cmd)
    );

    // The back end owns the read position and emits one output per cycle while the output is not stalled.
    lir_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_q16      (step_reg),
        .cmd_valid     (pop_valid),
        .cmd_pop       (pop_en),
        .cmd           (pop_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_sample  (m_out_sample),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

[verif/linear_interp_resampler_core_tb.sv]
`default_nettype none

module linear_interp_resampler_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lir_pkg::*;

    // Each input sample yields at most this many interpolated outputs. That is
    // the number of outputs that fit below one at the smallest allowed step.
    localparam int MAX_RUN = 64;

    // Idle cycles allowed after the last expected output before the
    // registers are touched. A sample that yields no output still occupies
    // the sequencer behind the queue, multiply stage and output register.
    localparam int SETTLE_CYCLES = 12;

    // Scoreboard: it mirrors the configuration and the interpolator state,
    // predicts the outputs of every accepted input request, and checks each
    // accepted output request against the oldest prediction.
    class resampler_scoreboard;

        typedef struct {
            logic signed [SAMPLE_W-1:0] sample;
            logic                       last;
        } out_item_t;

        out_item_t                  due_outputs[$];
        logic [STEP_W-1:0]          step_reg;
        logic                       bypass_reg;
        logic signed [SAMPLE_W-1:0] prev_sample;
        logic                       have_prev;
        logic [POS_W-1:0]           position;
        int                         errors;
        int                         checked;
        int                         passed_through;
        int                         samples_in;

        function new();
            step_reg       = STEP_ONE;
            bypass_reg     = 1'b1;
            prev_sample    = '0;
            have_prev      = 1'b0;
            position       = '0;
            errors         = 0;
            checked        = 0;
            passed_through = 0;
            samples_in     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_STEP) begin
                step_reg = value[STEP_W-1:0];
            end else if (idx == REG_BYPASS) begin
                bypass_reg = value[0];
            end
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction

        // prev + pos * (next - prev), rounded half away from zero, clamped.
        function logic signed [SAMPLE_W-1:0] lerp_round(logic signed [SAMPLE_W-1:0] a,
                                                        logic signed [SAMPLE_W-1:0] b,
                                                        logic [POS_W-1:0] pos);
            longint num;
            longint mag;
            longint rounded;
            num = (longint'(a) <<< FRAC_BITS) + longint'(pos) * (longint'(b) - longint'(a));
            mag = (num < 0) ? -num : num;
            rounded = (mag + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (num < 0) begin
                rounded = -rounded;
            end
            if (rounded > longint'(SAMPLE_MAX)) begin
                rounded = longint'(SAMPLE_MAX);
            end
            if (rounded < longint'(SAMPLE_MIN)) begin
                rounded = longint'(SAMPLE_MIN);
            end
            return rounded[SAMPLE_W-1:0];
        endfunction

        function void accept_sample(logic signed [SAMPLE_W-1:0] x);
            out_item_t         item;
            logic [STEP_W-1:0] eff_step;
            int                n;
            samples_in++;
            eff_step = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
            n = 0;
            if (bypass_reg) begin
                // Bypass leaves the interpolator state untouched.
                item.sample = x;
                item.last   = 1'b1;
                due_outputs = {due_outputs, item};
                passed_through++;
            end else if (!have_prev) begin
                prev_sample = x;
                have_prev   = 1'b1;
            end else begin
                while (position < POS_ONE && n < MAX_RUN) begin
                    item.sample = lerp_round(prev_sample, x, position);
                    position    = position + POS_W'(eff_step);
                    n++;
                    item.last   = (position >= POS_ONE) || (n == MAX_RUN);
                    due_outputs = {due_outputs, item};
                end
                if (position >= POS_ONE) begin
                    position = position - POS_ONE;
                end
                prev_sample = x;
            end
        endfunction

        function void check_output(logic signed [SAMPLE_W-1:0] got_sample, logic got_last);
            out_item_t want;
            if (due_outputs.size() == 0) begin
                $display("%0t ns: unexpected output, expected none, got sample %0d last %0b",
                         $time, got_sample, got_last);
                errors++;
                return;
            end
            want = due_outputs.pop_front();
            checked++;
            if (got_sample !== want.sample) begin
                $display("%0t ns: out_sample expected %0d, got %0d",
                         $time, want.sample, got_sample);
                errors++;
            end
            if (got_last !== want.last) begin
                $display("%0t ns: last_of_run expected %0b, got %0b",
                         $time, want.last, got_last);
                errors++;
            end
        endfunction

    endclass

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index     = '0;
    logic [CFG_W-1:0]           cfg_wdata     = '0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_in_sample   = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_sample;
    logic                       m_last_of_run;

    resampler_scoreboard sb = new();

    // When set, the sender issues requests back to back with no gaps.
    bit steady_sender = 1'b0;
    int settings_used = 0;
    int unsigned ready_left = 0;

    linear_interp_resampler_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_sample   (s_in_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_sample  (m_out_sample),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Output backpressure. The receiver alternates between segments of
    // random length: long stretches that are always ready, short bursts,
    // short stalls and occasional long stalls, so that stalls land on every
    // position within a run of outputs.
    always @(posedge aclk) begin
        int unsigned pick;
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(40, 200);
            end else if (pick < 55) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(0, 4);
            end else if (pick < 93) begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(0, 2);
            end else begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(8, 40);
            end
        end
    end

    // Output monitor. Signals are read at the clock edge, before any update
    // scheduled by that edge, so the values seen are the ones the edge uses.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_output(m_out_sample, m_last_of_run);
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (steady_sender || pick < 60) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random audio content: full-scale extremes, values near zero, and
    // arbitrary words that exercise every bit of the sample.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return SAMPLE_MAX;
        end else if (pick < 10) begin
            return SAMPLE_MIN;
        end else if (pick < 30) begin
            return SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
        end
        return SAMPLE_W'($urandom);
    endfunction

    // Step choice. Most settings upsample by a modest ratio so that runs stay
    // short; a few use the smallest steps (including ones below the floor)
    // and a few downsample, where many inputs yield no output at all.
    function automatic logic [STEP_W-1:0] pick_step();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            return STEP_W'($urandom_range(0, 1024));
        end else if (pick < 15) begin
            return (pick < 11) ? STEP_W'(10923) : STEP_W'(60211);
        end else if (pick < 35) begin
            return STEP_W'($urandom_range(1025, 8191));
        end else if (pick < 82) begin
            return STEP_W'($urandom_range(8192, 65536));
        end
        return STEP_W'($urandom_range(65537, 1048575));
    endfunction

    // One input request. Valid is only dropped when a gap follows, so that a
    // back-to-back request never sees valid lowered and raised in one step.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_sample <= x;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.accept_sample(x);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(input logic [STEP_W-1:0] step, input logic bypass_on);
        write_register(REG_STEP, CFG_W'(step));
        write_register(REG_BYPASS, CFG_W'(bypass_on));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Stops sending and waits until every predicted output has been seen,
    // then lets the pipeline settle for the given number of cycles. Valid is
    // lowered before the wait so that a following request never raises it
    // again in the same step.
    task automatic wait_outputs_drained(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (settle) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset leaves the block in bypass, so full-scale and sign-boundary
        // samples must come straight back out, one output each.
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        wait_outputs_drained(SETTLE_CYCLES);

        // Interpolation at a step of exactly one. The first sample only
        // primes the interpolator; every later one yields the previous
        // sample, including the largest possible swings.
        apply_settings(STEP_ONE, 1'b0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd0);
        wait_outputs_drained(SETTLE_CYCLES);

        // A bypassed sample in between must not disturb the stored sample.
        apply_settings(STEP_ONE, 1'b1);
        send_sample(16'sd1234);
        wait_outputs_drained(SETTLE_CYCLES);

        // Half step: the midpoints 0.5, 0.5 and -0.5 check rounding away
        // from zero in both directions.
        apply_settings(STEP_ONE >> 1, 1'b0);
        send_sample(16'sd1);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        wait_outputs_drained(SETTLE_CYCLES);

        // Smallest step: the longest runs of outputs, over full-scale swings.
        apply_settings(STEP_MIN, 1'b0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        wait_outputs_drained(SETTLE_CYCLES);

        // A step of zero is raised to the floor.
        apply_settings('0, 1'b0);
        send_sample(16'sd100);
        wait_outputs_drained(SETTLE_CYCLES);

        // Largest step: one output, then inputs that only walk the position
        // back down by one each.
        apply_settings('1, 1'b0);
        repeat (5) send_sample(pick_sample());
        wait_outputs_drained(SETTLE_CYCLES);

        // The usual 8 kHz to 48 kHz ratio.
        apply_settings(STEP_W'(10923), 1'b0);
        repeat (3) send_sample(pick_sample());
        wait_outputs_drained(SETTLE_CYCLES);

        // Random part: ten settings of about twenty-two samples each. The
        // position and the stored sample carry over from one setting to the
        // next, as they would in the block.
        for (int phase = 0; phase < 10; phase++) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            apply_settings(pick_step(), ($urandom_range(0, 4) == 0));
            for (int k = 0; k < 22; k++) begin
                send_sample(pick_sample());
                // Now and then, and once for certain, the sender holds off
                // until every outstanding output has been delivered.
                if ((phase == 2 && k == 10) || $urandom_range(0, 49) == 0) begin
                    wait_outputs_drained(0);
                end
            end
            wait_outputs_drained(SETTLE_CYCLES);
        end

        wait_outputs_drained(20);

        $display("Run covered %0d input samples under %0d register settings.",
                 sb.samples_in, settings_used);
        $display("Checked %0d outputs, %0d of them passed through in bypass.",
                 sb.checked, sb.passed_through);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, even with every output
    // stalled for the longest gap.
    initial begin
        #30ms;
        $display("Timed out with %0d outputs still expected.", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/lir_pkg.sv
rtl/lir_front.sv
rtl/lir_cmd_fifo.sv
rtl/lir_back.sv
rtl/linear_interp_resampler_core.sv
verif/linear_interp_resampler_core_tb.sv
